### hw/rtl/max_flow_bfs_augment_unit_macros.svh
// Assertion macros shared by the checker of the max flow unit.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef MAX_FLOW_BFS_AUGMENT_UNIT_MACROS_SVH
`define MAX_FLOW_BFS_AUGMENT_UNIT_MACROS_SVH

// Checked only while the block is out of reset.
`define MFB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MFB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/mfb_pkg.sv
// Package of the max flow unit: sizes, sequencer states, datapath operations
// and the command and status structs. Depends on nothing.
package mfb_pkg;

    localparam int MAX_NODES = 512;
    localparam int NODE_W    = 9;
    localparam int NCNT_W    = 10;
    localparam int MAX_EDGES = 1024;
    localparam int SLOTS     = 2 * MAX_EDGES;
    localparam int SLOT_W    = 11;
    localparam int HEAD_W    = 12;
    localparam int CNT_W     = 11;
    localparam int CAP_W     = 32;
    localparam int FLOW_W    = 42;
    localparam int QPTR_W    = 10;

    localparam logic [HEAD_W-1:0] NO_SLOT     = HEAD_W'(SLOTS);
    localparam logic [CAP_W-1:0]  CAP_ALL     = '1;
    localparam logic [NCNT_W-1:0] NODES_RESET = NCNT_W'(2);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_LD1, S_LD2, S_LD3, S_VCLR, S_BINIT, S_POP, S_POP2,
        S_HEAD, S_EDGE, S_EDGE2, S_EDGE3, S_A1, S_A2, S_A3, S_A4, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_ACCEPT, OP_LD1, OP_LD2, OP_LD3, OP_VCLR, OP_BINIT,
        OP_POP, OP_POP2, OP_HEAD, OP_EDGE, OP_EDGE2, OP_EDGE3, OP_A1, OP_A2,
        OP_A3, OP_A4, OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic edge_ok;
        logic last;
        logic clr_done;
        logic q_empty;
        logic slot_end;
        logic take;
        logic hit_sink;
        logic x_zero;
        logic out_busy;
    } t_sts;

endpackage

### hw/rtl/mfb_ctrl.sv
// Sequencer of the max flow unit: loading, search, augmentation and result.
// Depends on mfb_pkg.
module mfb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  mfb_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output mfb_pkg::t_cmd o_cmd
);

    mfb_pkg::t_state r_state;
    mfb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfb_pkg::S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mfb_pkg::S_CLR:   if (i_sts.clr_done) n_state = mfb_pkg::S_IDLE;
            mfb_pkg::S_IDLE:  if (i_in_valid) n_state = mfb_pkg::S_LD1;
            mfb_pkg::S_LD1: begin
                if (i_sts.edge_ok) n_state = mfb_pkg::S_LD2;
                else if (i_sts.last) n_state = mfb_pkg::S_VCLR;
                else n_state = mfb_pkg::S_IDLE;
            end
            mfb_pkg::S_LD2:   n_state = mfb_pkg::S_LD3;
            mfb_pkg::S_LD3:   n_state = i_sts.last ? mfb_pkg::S_VCLR : mfb_pkg::S_IDLE;
            mfb_pkg::S_VCLR:  if (i_sts.clr_done) n_state = mfb_pkg::S_BINIT;
            mfb_pkg::S_BINIT: n_state = mfb_pkg::S_POP;
            mfb_pkg::S_POP:   n_state = i_sts.q_empty ? mfb_pkg::S_OUT : mfb_pkg::S_POP2;
            mfb_pkg::S_POP2:  n_state = mfb_pkg::S_HEAD;
            mfb_pkg::S_HEAD:  n_state = mfb_pkg::S_EDGE;
            mfb_pkg::S_EDGE:  n_state = i_sts.slot_end ? mfb_pkg::S_POP : mfb_pkg::S_EDGE2;
            mfb_pkg::S_EDGE2: n_state = mfb_pkg::S_EDGE3;
            mfb_pkg::S_EDGE3: begin
                n_state = (i_sts.take && i_sts.hit_sink) ? mfb_pkg::S_A1 : mfb_pkg::S_EDGE;
            end
            mfb_pkg::S_A1:    n_state = i_sts.x_zero ? mfb_pkg::S_VCLR : mfb_pkg::S_A2;
            mfb_pkg::S_A2:    n_state = mfb_pkg::S_A3;
            mfb_pkg::S_A3:    n_state = mfb_pkg::S_A4;
            mfb_pkg::S_A4:    n_state = mfb_pkg::S_A1;
            mfb_pkg::S_OUT:   if (!i_sts.out_busy) n_state = mfb_pkg::S_CLR;
            default:          n_state = mfb_pkg::S_CLR;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = mfb_pkg::OP_NONE;
        unique case (r_state)
            mfb_pkg::S_CLR:   o_cmd.op = mfb_pkg::OP_CLR;
            mfb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = mfb_pkg::OP_ACCEPT;
            end
            mfb_pkg::S_LD1:   o_cmd.op = mfb_pkg::OP_LD1;
            mfb_pkg::S_LD2:   o_cmd.op = mfb_pkg::OP_LD2;
            mfb_pkg::S_LD3:   o_cmd.op = mfb_pkg::OP_LD3;
            mfb_pkg::S_VCLR:  o_cmd.op = mfb_pkg::OP_VCLR;
            mfb_pkg::S_BINIT: o_cmd.op = mfb_pkg::OP_BINIT;
            mfb_pkg::S_POP:   o_cmd.op = mfb_pkg::OP_POP;
            mfb_pkg::S_POP2:  o_cmd.op = mfb_pkg::OP_POP2;
            mfb_pkg::S_HEAD:  o_cmd.op = mfb_pkg::OP_HEAD;
            mfb_pkg::S_EDGE:  o_cmd.op = mfb_pkg::OP_EDGE;
            mfb_pkg::S_EDGE2: o_cmd.op = mfb_pkg::OP_EDGE2;
            mfb_pkg::S_EDGE3: o_cmd.op = mfb_pkg::OP_EDGE3;
            mfb_pkg::S_A1:    o_cmd.op = mfb_pkg::OP_A1;
            mfb_pkg::S_A2:    o_cmd.op = mfb_pkg::OP_A2;
            mfb_pkg::S_A3:    o_cmd.op = mfb_pkg::OP_A3;
            mfb_pkg::S_A4:    o_cmd.op = mfb_pkg::OP_A4;
            mfb_pkg::S_OUT:   if (!i_sts.out_busy) o_cmd.op = mfb_pkg::OP_OUT;
            default:          o_cmd.op = mfb_pkg::OP_NONE;
        endcase
    end

endmodule

### hw/rtl/mfb_dp.sv
// Datapath of the max flow unit: edge, adjacency, search and queue memories,
// cursors, bottleneck, flow total and result register. Depends on mfb_pkg.
module mfb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mfb_pkg::t_cmd                 i_cmd,
    output mfb_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_valid,
    input  logic [mfb_pkg::NCNT_W-1:0]    i_cfg_node_count,
    input  logic [mfb_pkg::NODE_W-1:0]    i_from_node,
    input  logic [mfb_pkg::NODE_W-1:0]    i_to_node,
    input  logic [mfb_pkg::CAP_W-1:0]     i_capacity,
    input  logic                          i_last_edge,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mfb_pkg::FLOW_W-1:0]    o_total_flow_out
);

    logic [mfb_pkg::NODE_W-1:0] edge_target   [mfb_pkg::SLOTS];
    logic [mfb_pkg::CAP_W-1:0]  edge_residual [mfb_pkg::SLOTS];
    logic [mfb_pkg::HEAD_W-1:0] edge_next     [mfb_pkg::SLOTS];
    logic [mfb_pkg::HEAD_W-1:0] node_head     [mfb_pkg::MAX_NODES];
    logic                       visited_mark  [mfb_pkg::MAX_NODES];
    logic [mfb_pkg::SLOT_W-1:0] parent_edge   [mfb_pkg::MAX_NODES];
    logic [mfb_pkg::NODE_W-1:0] queue_node    [mfb_pkg::MAX_NODES];
    logic [mfb_pkg::CAP_W-1:0]  queue_bneck   [mfb_pkg::MAX_NODES];

    logic [mfb_pkg::NODE_W-1:0] rd_tgt;
    logic [mfb_pkg::CAP_W-1:0]  rd_res;
    logic [mfb_pkg::HEAD_W-1:0] rd_next;
    logic [mfb_pkg::HEAD_W-1:0] rd_head;
    logic                       rd_vis;
    logic [mfb_pkg::SLOT_W-1:0] rd_par;
    logic [mfb_pkg::NODE_W-1:0] rd_qn;
    logic [mfb_pkg::CAP_W-1:0]  rd_qb;

    logic [mfb_pkg::NCNT_W-1:0] r_cfg;
    logic [mfb_pkg::NODE_W-1:0] r_from;
    logic [mfb_pkg::NODE_W-1:0] r_to;
    logic [mfb_pkg::CAP_W-1:0]  r_cap;
    logic                       r_last;
    logic                       r_edge_ok;
    logic [mfb_pkg::CNT_W-1:0]  r_cnt;
    logic [mfb_pkg::FLOW_W-1:0] r_flow;
    logic [mfb_pkg::NODE_W-1:0] r_idx;
    logic [mfb_pkg::QPTR_W-1:0] r_qh;
    logic [mfb_pkg::QPTR_W-1:0] r_qt;
    logic [mfb_pkg::NODE_W-1:0] r_x;
    logic [mfb_pkg::NODE_W-1:0] r_y;
    logic [mfb_pkg::CAP_W-1:0]  r_b;
    logic [mfb_pkg::CAP_W-1:0]  r_nb;
    logic [mfb_pkg::HEAD_W-1:0] r_s;
    logic [mfb_pkg::HEAD_W-1:0] r_nxt;
    logic                       r_out_valid;
    logic [mfb_pkg::FLOW_W-1:0] r_out;

    logic [mfb_pkg::NCNT_W-1:0] eff_n;
    logic [mfb_pkg::NODE_W-1:0] sink;
    logic [mfb_pkg::SLOT_W-1:0] slot0;
    logic [mfb_pkg::SLOT_W-1:0] slot1;
    logic [mfb_pkg::SLOT_W-1:0] s_low;
    logic [mfb_pkg::SLOT_W-1:0] s_mate;

    logic                       e_we;
    logic                       res_we;
    logic [mfb_pkg::SLOT_W-1:0] e_wa;
    logic [mfb_pkg::NODE_W-1:0] tgt_wd;
    logic [mfb_pkg::CAP_W-1:0]  res_wd;
    logic [mfb_pkg::HEAD_W-1:0] next_wd;
    logic [mfb_pkg::SLOT_W-1:0] e_ra;
    logic [mfb_pkg::SLOT_W-1:0] res_ra;
    logic                       h_we;
    logic [mfb_pkg::NODE_W-1:0] h_wa;
    logic [mfb_pkg::HEAD_W-1:0] h_wd;
    logic [mfb_pkg::NODE_W-1:0] h_ra;
    logic                       v_we;
    logic [mfb_pkg::NODE_W-1:0] v_wa;
    logic                       v_wd;
    logic                       p_we;
    logic                       q_we;
    logic [mfb_pkg::NODE_W-1:0] q_wa;
    logic [mfb_pkg::NODE_W-1:0] qn_wd;
    logic [mfb_pkg::CAP_W-1:0]  qb_wd;
    logic                       take;

    always_comb begin
        if (r_cfg < mfb_pkg::NCNT_W'(2)) begin
            eff_n = mfb_pkg::NCNT_W'(2);
        end else if (r_cfg > mfb_pkg::NCNT_W'(mfb_pkg::MAX_NODES)) begin
            eff_n = mfb_pkg::NCNT_W'(mfb_pkg::MAX_NODES);
        end else begin
            eff_n = r_cfg;
        end
    end

    assign sink   = mfb_pkg::NODE_W'(eff_n - mfb_pkg::NCNT_W'(1));
    assign slot0  = {r_cnt[mfb_pkg::SLOT_W-2:0], 1'b0};
    assign slot1  = {r_cnt[mfb_pkg::SLOT_W-2:0], 1'b1};
    assign s_low  = r_s[mfb_pkg::SLOT_W-1:0];
    assign s_mate = s_low ^ mfb_pkg::SLOT_W'(1);
    assign take   = (r_nb != '0) && !rd_vis;

    always_comb begin
        e_we    = 1'b0;
        res_we  = 1'b0;
        e_wa    = slot0;
        tgt_wd  = r_to;
        res_wd  = r_cap;
        next_wd = rd_head;
        e_ra    = s_low;
        res_ra  = s_low;
        h_we    = 1'b0;
        h_wa    = r_from;
        h_wd    = {1'b0, slot0};
        h_ra    = r_to;
        v_we    = 1'b0;
        v_wa    = r_idx;
        v_wd    = 1'b0;
        p_we    = 1'b0;
        q_we    = 1'b0;
        q_wa    = r_qt[mfb_pkg::NODE_W-1:0];
        qn_wd   = r_y;
        qb_wd   = r_nb;
        case (i_cmd.op)
            mfb_pkg::OP_CLR: begin
                h_we = 1'b1;
                h_wa = r_idx;
                h_wd = mfb_pkg::NO_SLOT;
            end
            mfb_pkg::OP_ACCEPT: h_ra = i_from_node;
            mfb_pkg::OP_LD1: begin
                e_we   = r_edge_ok;
                res_we = r_edge_ok;
                h_we   = r_edge_ok;
            end
            mfb_pkg::OP_LD3: begin
                e_we   = 1'b1;
                res_we = 1'b1;
                e_wa   = slot1;
                tgt_wd = r_from;
                res_wd = '0;
                h_we   = 1'b1;
                h_wa   = r_to;
                h_wd   = {1'b0, slot1};
            end
            mfb_pkg::OP_VCLR: v_we = 1'b1;
            mfb_pkg::OP_BINIT: begin
                v_we  = 1'b1;
                v_wa  = '0;
                v_wd  = 1'b1;
                q_we  = 1'b1;
                q_wa  = '0;
                qn_wd = '0;
                qb_wd = mfb_pkg::CAP_ALL;
            end
            mfb_pkg::OP_POP2: h_ra = rd_qn;
            mfb_pkg::OP_EDGE3: begin
                v_we = take;
                v_wa = r_y;
                v_wd = 1'b1;
                p_we = take;
                q_we = take && (r_y != sink);
            end
            mfb_pkg::OP_A2: res_ra = rd_par;
            mfb_pkg::OP_A3: begin
                res_we = 1'b1;
                e_wa   = s_low;
                res_wd = rd_res - r_b;
                e_ra   = s_mate;
                res_ra = s_mate;
            end
            mfb_pkg::OP_A4: begin
                res_we = 1'b1;
                e_wa   = s_mate;
                res_wd = rd_res + r_b;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            edge_target[e_wa] <= tgt_wd;
            edge_next[e_wa]   <= next_wd;
        end
        rd_tgt  <= edge_target[e_ra];
        rd_next <= edge_next[e_ra];
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            edge_residual[e_wa] <= res_wd;
        end
        rd_res <= edge_residual[res_ra];
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            node_head[h_wa] <= h_wd;
        end
        rd_head <= node_head[h_ra];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            visited_mark[v_wa] <= v_wd;
        end
        rd_vis <= visited_mark[rd_tgt];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            parent_edge[r_y] <= s_low;
        end
        rd_par <= parent_edge[r_x];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            queue_node[q_wa]  <= qn_wd;
            queue_bneck[q_wa] <= qb_wd;
        end
        rd_qn <= queue_node[r_qh[mfb_pkg::NODE_W-1:0]];
        rd_qb <= queue_bneck[r_qh[mfb_pkg::NODE_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= mfb_pkg::NODES_RESET;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_flow      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_node_count;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == mfb_pkg::OP_CLR || i_cmd.op == mfb_pkg::OP_VCLR) begin
                r_idx <= r_idx + mfb_pkg::NODE_W'(1);
            end else begin
                r_idx <= '0;
            end
            case (i_cmd.op)
                mfb_pkg::OP_CLR: begin
                    r_cnt  <= '0;
                    r_flow <= '0;
                end
                mfb_pkg::OP_LD3: r_cnt <= r_cnt + mfb_pkg::CNT_W'(1);
                mfb_pkg::OP_EDGE3: begin
                    if (take && r_y == sink) begin
                        r_flow <= r_flow + mfb_pkg::FLOW_W'(r_nb);
                    end
                end
                mfb_pkg::OP_OUT: r_out_valid <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            mfb_pkg::OP_ACCEPT: begin
                r_from    <= i_from_node;
                r_to      <= i_to_node;
                r_cap     <= i_capacity;
                r_last    <= i_last_edge;
                r_edge_ok <= (mfb_pkg::NCNT_W'(i_from_node) < eff_n)
                          && (mfb_pkg::NCNT_W'(i_to_node) < eff_n)
                          && !r_cnt[mfb_pkg::CNT_W-1];
            end
            mfb_pkg::OP_BINIT: begin
                r_qh <= '0;
                r_qt <= mfb_pkg::QPTR_W'(1);
            end
            mfb_pkg::OP_POP2: begin
                r_x  <= rd_qn;
                r_b  <= rd_qb;
                r_qh <= r_qh + mfb_pkg::QPTR_W'(1);
            end
            mfb_pkg::OP_HEAD: r_s <= rd_head;
            mfb_pkg::OP_EDGE2: begin
                r_y   <= rd_tgt;
                r_nb  <= (rd_res < r_b) ? rd_res : r_b;
                r_nxt <= rd_next;
            end
            mfb_pkg::OP_EDGE3: begin
                r_s <= r_nxt;
                if (take && r_y == sink) begin
                    r_b <= r_nb;
                    r_x <= sink;
                end else if (take) begin
                    r_qt <= r_qt + mfb_pkg::QPTR_W'(1);
                end
            end
            mfb_pkg::OP_A2: r_s <= {1'b0, rd_par};
            mfb_pkg::OP_A4: r_x <= rd_tgt;
            mfb_pkg::OP_OUT: r_out <= r_flow;
            default: begin
            end
        endcase
    end

    assign o_sts.edge_ok  = r_edge_ok;
    assign o_sts.last     = r_last;
    assign o_sts.clr_done = (r_idx == mfb_pkg::NODE_W'(mfb_pkg::MAX_NODES - 1));
    assign o_sts.q_empty  = (r_qh == r_qt);
    assign o_sts.slot_end = r_s[mfb_pkg::HEAD_W-1];
    assign o_sts.take     = take;
    assign o_sts.hit_sink = (r_y == sink);
    assign o_sts.x_zero   = (r_x == '0);
    assign o_sts.out_busy = r_out_valid;

    assign o_out_valid      = r_out_valid;
    assign o_total_flow_out = r_out;

endmodule

### hw/rtl/max_flow_bfs_augment_unit.sv
// Top level of the max flow unit: sequencer plus datapath.
// Depends on mfb_pkg, mfb_ctrl and mfb_dp.
//
// Edges arrive on the input channel as one transaction each (from node, to
// node, capacity, last mark). A stored edge passes the LD1, LD2 and LD3
// states before the next ready, a dropped edge LD1 only; ready is low in
// between. Edges with a node at or above the node count (clamped to 2..512),
// or arriving after 1024 have been stored, are dropped.
// The transaction carrying the last mark starts the computation. Each
// breadth-first search first clears the visited marks of all 512 nodes, then
// dequeues each node through POP, POP2 and HEAD and scans each of its edges
// through EDGE, EDGE2 and EDGE3. Each augmentation steps through A1 to A4
// once per edge of the path. When no path remains, the total flow is placed
// in the output register as one transaction.
// The output register holds the result while the receiver stalls; the unit
// meanwhile clears all 512 adjacency heads and then takes edges of the
// next graph, but it does not present a new result before the old one
// is taken.
// After reset, the same clearing pass runs before the first edge
// is accepted. The node count register resets to 2 and may be written on
// the configuration channel at any time the unit is idle.
module max_flow_bfs_augment_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mfb_pkg::NCNT_W-1:0]    i_cfg_node_count,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mfb_pkg::NODE_W-1:0]    i_from_node,
    input  logic [mfb_pkg::NODE_W-1:0]    i_to_node,
    input  logic [mfb_pkg::CAP_W-1:0]     i_capacity,
    input  logic                          i_last_edge,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mfb_pkg::FLOW_W-1:0]    o_total_flow_out
);

    mfb_pkg::t_cmd cmd;
    mfb_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    mfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    mfb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_node_count (i_cfg_node_count),
        .i_from_node      (i_from_node),
        .i_to_node        (i_to_node),
        .i_capacity       (i_capacity),
        .i_last_edge      (i_last_edge),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_total_flow_out (o_total_flow_out)
    );

endmodule

### hw/rtl/mfb_checker.sv
// Port-level checker of the max flow unit, bound to the top level.
// Depends on mfb_pkg and max_flow_bfs_augment_unit_macros.svh.
`include "max_flow_bfs_augment_unit_macros.svh"

module mfb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [mfb_pkg::FLOW_W-1:0] o_total_flow_out
);

    `MFB_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_total_flow_out), "Result changed or vanished before its transaction.")
    `MFB_ASSERT(a_load_busy, i_in_valid && o_in_ready |=> !o_in_ready, "Input accepted on two cycles in a row.")
    `MFB_ASSERT(a_one_result, o_out_valid && i_out_ready |=> !o_out_valid, "Result presented again right after its transaction.")
    `MFB_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_out_valid && !o_in_ready, "Unit not quiet after reset.")

endmodule

bind max_flow_bfs_augment_unit mfb_checker u_mfb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_total_flow_out (o_total_flow_out)
);

### test/tb_max_flow_bfs_augment_unit.sv
// Self-checking testbench for max_flow_bfs_augment_unit: drives edge lists, node counts and
// output stalls, and checks each total flow against an Edmonds-Karp predictor.
// Depends on mfb_pkg and the max_flow_bfs_augment_unit RTL.
`timescale 1ns / 1ps

class flow_scoreboard;
    bit [mfb_pkg::NCNT_W-1:0] node_cfg;
    bit [8:0]                 slot_target [mfb_pkg::SLOTS];
    longint unsigned          slot_resid  [mfb_pkg::SLOTS];
    int                       slot_next   [mfb_pkg::SLOTS];
    int                       node_first  [mfb_pkg::MAX_NODES];
    int                       parent_slot [mfb_pkg::MAX_NODES];
    int                       edge_count;
    bit [41:0]                flow_sum;
    bit [41:0]                flow_expected_q [$];
    int                       mismatches;

    function new();
        node_cfg   = mfb_pkg::NODES_RESET;
        mismatches = 0;
        clear_graph();
    endfunction

    function int active_nodes();
        if (node_cfg < 2) return 2;
        if (node_cfg > mfb_pkg::MAX_NODES) return mfb_pkg::MAX_NODES;
        return int'(node_cfg);
    endfunction

    function void clear_graph();
        foreach (node_first[i]) node_first[i] = mfb_pkg::SLOTS;
        edge_count = 0;
        flow_sum   = '0;
    endfunction

    function void link_slot(int s, int src, int dst, longint unsigned res);
        slot_target[s] = 9'(dst);
        slot_resid[s]  = res;
        slot_next[s]   = node_first[src];
        node_first[src] = s;
    endfunction

    // Breadth-first search from node 0; returns the path bottleneck, or zero.
    function longint unsigned find_path(int n);
        int              qnode [mfb_pkg::MAX_NODES];
        longint unsigned qbott [mfb_pkg::MAX_NODES];
        bit              seen  [mfb_pkg::MAX_NODES];
        int              qh, qt, x, s, y;
        longint unsigned b, nb;
        foreach (seen[i]) seen[i] = 1'b0;
        seen[0]  = 1'b1;
        qnode[0] = 0;
        qbott[0] = 64'hFFFF_FFFF;
        qh = 0;
        qt = 1;
        while (qh < qt) begin
            x = qnode[qh];
            b = qbott[qh];
            s = node_first[x];
            qh++;
            while (s < mfb_pkg::SLOTS) begin
                y  = int'(slot_target[s]);
                nb = (slot_resid[s] < b) ? slot_resid[s] : b;
                if (nb > 0 && !seen[y]) begin
                    seen[y] = 1'b1;
                    parent_slot[y] = s;
                    if (y == n - 1) return nb;
                    if (qt < mfb_pkg::MAX_NODES) begin
                        qnode[qt] = y;
                        qbott[qt] = nb;
                        qt++;
                    end
                end
                s = slot_next[s];
            end
        end
        return 0;
    endfunction

    function void note_edge(bit [8:0] src, bit [8:0] dst, bit [31:0] cap, bit last);
        int              n, x, s;
        longint unsigned b;
        n = active_nodes();
        if (src < n && dst < n && edge_count < mfb_pkg::MAX_EDGES) begin
            link_slot(2 * edge_count, int'(src), int'(dst), 64'(cap));
            link_slot(2 * edge_count + 1, int'(dst), int'(src), 64'd0);
            edge_count++;
        end
        if (last) begin
            b = find_path(n);
            while (b != 0) begin
                flow_sum = flow_sum + b[41:0];
                x = n - 1;
                while (x != 0) begin
                    s = parent_slot[x];
                    slot_resid[s]     -= b;
                    slot_resid[s ^ 1] += b;
                    x = int'(slot_target[s ^ 1]);
                end
                b = find_path(n);
            end
            flow_expected_q = {flow_expected_q, flow_sum};
            clear_graph();
        end
    endfunction

    function void check_flow(bit [41:0] got);
        bit [41:0] want;
        if (flow_expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected total flow transaction: expected none, actual %0d", got);
            return;
        end
        want = flow_expected_q.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Total flow mismatch: expected %0d, actual %0d", want, got);
        end
    endfunction

    function int pending();
        return flow_expected_q.size();
    endfunction
endclass

module tb_max_flow_bfs_augment_unit;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [mfb_pkg::NCNT_W-1:0] i_cfg_node_count = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [mfb_pkg::NODE_W-1:0] i_from_node = '0;
    logic [mfb_pkg::NODE_W-1:0] i_to_node = '0;
    logic [mfb_pkg::CAP_W-1:0]  i_capacity = '0;
    logic                       i_last_edge = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [mfb_pkg::FLOW_W-1:0] o_total_flow_out;

    flow_scoreboard flow_sb = new();
    int             cycle_count = 0;
    int             edges_sent = 0;
    int             stall_phase = 0;
    int             stall_mode = 0;

    max_flow_bfs_augment_unit i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) flow_sb.node_cfg = i_cfg_node_count;
            if (i_in_valid && o_in_ready)
                flow_sb.note_edge(i_from_node, i_to_node, i_capacity, i_last_edge);
            if (o_out_valid && i_out_ready) flow_sb.check_flow(o_total_flow_out);
        end
    end

    // Receiver stalls follow one of four patterns, redrawn at random as the phase counter advances.
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= (stall_phase % 7) < 3;
            2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= ((stall_phase / 40) % 2 == 0);
        endcase
    end

    task automatic send_edge(int src, int dst, bit [31:0] cap, bit last);
        i_from_node <= mfb_pkg::NODE_W'(src);
        i_to_node   <= mfb_pkg::NODE_W'(dst);
        i_capacity  <= cap;
        i_last_edge <= last;
        i_in_valid  <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        edges_sent++;
        if ($urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain_flows();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (flow_sb.pending() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
    endtask

    task automatic write_nodes(int value);
        drain_flows();
        i_cfg_node_count <= mfb_pkg::NCNT_W'(value);
        i_cfg_valid      <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic bit [31:0] pick_capacity();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(1, 100);
        endcase
    endfunction

    task automatic send_graph(int n, int count);
        int src, dst;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                src = $urandom_range(0, 511);
                dst = $urandom_range(0, 511);
            end else begin
                src = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, n - 1);
                dst = ($urandom_range(0, 3) == 0) ? n - 1 : $urandom_range(0, n - 1);
            end
            send_edge(src, dst, pick_capacity(), k == count - 1);
        end
    endtask

    initial begin
        int n_cfg, n_eff;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Lone last edge at the reset node count, full capacity.
        send_edge(0, 1, 32'hFFFF_FFFF, 1'b1);

        write_nodes(4);
        send_edge(0, 1, 32'hFFFF_FFFF, 1'b0);
        send_edge(1, 3, 32'hFFFF_FFFF, 1'b0);
        send_edge(0, 3, 32'd0, 1'b0);
        send_edge(2, 2, 32'd9, 1'b0);
        send_edge(0, 2, 32'd5, 1'b0);
        send_edge(2, 3, 32'd7, 1'b0);
        send_edge(511, 0, 32'd3, 1'b0);
        send_edge(3, 0, 32'd1, 1'b1);
        send_edge(0, 3, 32'd11, 1'b0);
        send_edge(0, 4, 32'd13, 1'b1);

        write_nodes(0);
        send_edge(0, 1, 32'd17, 1'b0);
        send_edge(1, 1, 32'd4, 1'b1);
        write_nodes(1);
        send_edge(0, 1, 32'h8000_0001, 1'b1);
        write_nodes(1023);
        send_edge(0, 511, 32'hFFFF_FFFF, 1'b0);
        send_edge(0, 256, 32'h5555_5555, 1'b0);
        send_edge(256, 511, 32'hAAAA_AAAA, 1'b1);
        write_nodes(512);
        send_edge(511, 0, 32'd1, 1'b1);

        while (edges_sent < 650) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 7))
                    0: n_cfg = $urandom_range(0, 1);
                    1: n_cfg = 512;
                    2: n_cfg = $urandom_range(513, 1023);
                    3: n_cfg = $urandom_range(17, 511);
                    default: n_cfg = $urandom_range(2, 16);
                endcase
                write_nodes(n_cfg);
            end
            n_eff = flow_sb.active_nodes();
            send_graph(n_eff, $urandom_range(1, 20));
            if ($urandom_range(0, 7) == 0) drain_flows();
        end

        drain_flows();
        if (flow_sb.mismatches == 0 && flow_sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
